// ===== rtl/core/autotile_subtile_blit_generator_unit_defines.svh =====
// assertion macros shared by the blit generator rtl
`ifndef AUTOTILE_SUBTILE_BLIT_GENERATOR_UNIT_DEFINES_SVH
`define AUTOTILE_SUBTILE_BLIT_GENERATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASTBG_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASTBG_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define ASTBG_ASSERT(name, clk, rst, prop, msg)
`define ASTBG_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif

`endif

// ===== rtl/core/astbg_pkg.sv =====
// types and constants of the autotile blit generator
package astbg_pkg;

  localparam int MaxRects = 5;

  localparam logic [1:0] OP_WATER   = 2'd0;
  localparam logic [1:0] OP_TERRAIN = 2'd1;
  localparam logic [1:0] OP_DEPTH   = 2'd2;

  typedef struct packed {
    logic       ox;
    logic       oy;
    logic [7:0] sx;
    logic [7:0] sy;
    logic       w16;
    logic       h16;
  } blit_ent_t;

  typedef struct packed {
    logic [11:0]                    dest_x;
    logic [11:0]                    dest_y;
    logic [2:0]                     count;
    blit_ent_t [MaxRects-1:0]       e;
  } blit_item_t;

endpackage

// ===== rtl/core/astbg_tile_if.sv =====
// tile request channel
interface astbg_tile_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic [1:0]  frame;
  logic        border;
  logic [1:0]  water_row;
  logic [3:0]  terrain_index;
  logic [1:0]  depth_row;
  logic [5:0]  combination;

  modport source (
    output valid, operation, dest_x, dest_y, frame, border, water_row,
           terrain_index, depth_row, combination,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_x, dest_y, frame, border, water_row,
           terrain_index, depth_row, combination,
    output ready
  );
endinterface

// ===== rtl/core/astbg_blit_if.sv =====
// blit rectangle channel
interface astbg_blit_if;
  logic        valid;
  logic        ready;
  logic [11:0] dst_x;
  logic [11:0] dst_y;
  logic [7:0]  src_x;
  logic [7:0]  src_y;
  logic [4:0]  rect_width;
  logic [4:0]  rect_height;
  logic        last;

  modport source (
    output valid, dst_x, dst_y, src_x, src_y, rect_width, rect_height, last,
    input  ready
  );
  modport sink (
    input  valid, dst_x, dst_y, src_x, src_y, rect_width, rect_height, last,
    output ready
  );
endinterface

// ===== rtl/core/autotile_subtile_blit_generator_unit.sv =====
// autotile blit generator top level
//
// tile (sink): one transfer asks for one composed 16x16 tile of kind water,
// terrain or depth, with its destination, frame, border, rows, terrain index
// and 6-bit edge combination code.
// blit (source): the tile's blit rectangles in order, one transfer each,
// last set on the final one; a tile that yields no rectangle sends nothing.
// pipeline: input register, decode of the rectangle list and source bases,
// source coordinate adders, then a sequencer and output register.
// path: input, decode and adder registers, then the sequencer's held copy and
// the output register. throughput: one rectangle per cycle from the sequencer
// while blit ready is high; a tile has zero to five rectangles, and the next tile is taken as its last one is sent.
// a new tile is taken every cycle while the stages ahead have room.
// reset clears every valid bit; no rectangle is pending afterwards.
// when the receiver stalls the output register holds its rectangle, the
// stages fill up and tile ready drops; nothing is lost or repeated.
`include "autotile_subtile_blit_generator_unit_defines.svh"

module autotile_subtile_blit_generator_unit (
  input  logic         clk,
  input  logic         rst,
  astbg_tile_if.sink   tile,
  astbg_blit_if.source blit
);
  import astbg_pkg::*;

  typedef struct packed {
    logic       alt;
    logic       ox;
    logic       oy;
    logic [5:0] dx;
    logic [5:0] dy;
    logic       w16;
    logic       h16;
  } rect_ent_t;

  typedef struct packed {
    logic [2:0]               count;
    rect_ent_t [MaxRects-1:0] e;
  } rect_list_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [1:0]  frame;
    logic        border;
    logic [1:0]  water_row;
    logic [3:0]  terrain_index;
    logic [1:0]  depth_row;
    logic [5:0]  comb;
  } s1_t;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [7:0]  base_x;
    logic [7:0]  base_y;
    logic [7:0]  alt_x;
    logic [7:0]  alt_y;
    rect_list_t  list;
  } s2_t;

  function automatic rect_ent_t ent(input logic [3:0] ox, input logic [3:0] oy,
                                    input logic [5:0] dx, input logic [5:0] dy,
                                    input logic [4:0] w, input logic [4:0] h);
    rect_ent_t r;
    r.alt = 1'b0;
    r.ox  = ox[3];
    r.oy  = oy[3];
    r.dx  = dx;
    r.dy  = dy;
    r.w16 = w[4];
    r.h16 = h[4];
    return r;
  endfunction

  function automatic rect_list_t push(input rect_list_t l, input rect_ent_t e);
    rect_list_t r;
    r = l;
    if (l.count < 3'(MaxRects)) begin
      r.e[l.count] = e;
      r.count      = l.count + 3'd1;
    end
    return r;
  endfunction

  function automatic rect_list_t water_list(input logic [5:0] c);
    rect_list_t l;
    rect_ent_t  bg;
    l      = '0;
    bg     = ent(4'd0, 4'd0, 6'd0, 6'd0, 5'd16, 5'd16);
    bg.alt = 1'b1;
    l      = push(l, bg);
    if (c[5]) begin
      if (c > 6'h29) begin
        case (c)
          6'h2A: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd0, 5'd16, 5'd8));
            l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd24, 5'd16, 5'd8));
          end
          6'h2B: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd0, 5'd8, 5'd16));
            l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd32, 5'd8, 5'd16));
          end
          6'h2C: begin
            l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd8, 5'd16, 5'd8));
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd16, 5'd8));
          end
          6'h2D: begin
            l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd0, 5'd8, 5'd16));
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd32, 5'd8, 5'd16));
          end
          6'h2E: l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd0, 5'd16, 5'd16));
          default: ;
        endcase
      end else begin
        case (c[3:1])
          3'd0: begin
            if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd32, 5'd16, 5'd16));
            else      l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd16, 5'd16));
          end
          3'd1: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd0, 5'd8, 5'd8));
            l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd24, 5'd8, 5'd8));
            l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd32, 5'd8, 5'd8));
            if (c[0]) l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd56, 5'd8, 5'd8));
          end
          3'd2: begin
            l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd0, 5'd8, 5'd8));
            l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd24, 5'd8, 5'd8));
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd32, 5'd8, 5'd8));
            if (c[0]) l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd56, 5'd8, 5'd8));
          end
          3'd3: begin
            l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd8, 5'd8, 5'd8));
            l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd16, 5'd8, 5'd8));
            l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd40, 5'd8, 5'd8));
            if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd48, 5'd8, 5'd8));
          end
          3'd4: begin
            l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd8, 5'd8, 5'd8));
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd8, 5'd8));
            l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd40, 5'd8, 5'd8));
            if (c[0]) l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd48, 5'd8, 5'd8));
          end
          default: ;
        endcase
      end
    end else if (c[4]) begin
      case (c[3:2])
        2'd0: begin
          l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd8, 5'd16));
          if (c[0]) l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd48, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd56, 5'd8, 5'd8));
        end
        2'd1: begin
          l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd32, 5'd16, 5'd8));
          if (c[0]) l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd56, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd56, 5'd8, 5'd8));
        end
        2'd2: begin
          l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd16, 5'd8, 5'd16));
          if (c[0]) l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd56, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd48, 5'd8, 5'd8));
        end
        default: begin
          l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd40, 5'd16, 5'd8));
          if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd48, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd48, 5'd8, 5'd8));
        end
      endcase
    end else begin
      if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd48, 5'd8, 5'd8));
      if (c[1]) l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd48, 5'd8, 5'd8));
      if (c[2]) l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd56, 5'd8, 5'd8));
      if (c[3]) l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd56, 5'd8, 5'd8));
    end
    return l;
  endfunction

  function automatic rect_list_t terrain_list(input logic [5:0] c);
    rect_list_t l;
    l = '0;
    l = push(l, ent(4'd0, 4'd0, 6'd16, 6'd32, 5'd16, 5'd16));
    if (c[5]) begin
      if (c > 6'h29) begin
        case (c)
          6'h2A: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd8, 5'd16));
            l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd16, 5'd8, 5'd16));
          end
          6'h2B: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd16, 5'd8));
            l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd56, 5'd16, 5'd8));
          end
          6'h2C: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd48, 5'd8, 5'd16));
            l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd48, 5'd8, 5'd16));
          end
          6'h2D: begin
            l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd16, 5'd16, 5'd8));
            l = push(l, ent(4'd0, 4'd8, 6'd32, 6'd56, 5'd16, 5'd8));
          end
          6'h2E: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd8, 5'd8));
            l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd16, 5'd8, 5'd8));
            l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd56, 5'd8, 5'd8));
            l = push(l, ent(4'd8, 4'd8, 6'd40, 6'd56, 5'd8, 5'd8));
          end
          6'h31: l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd0, 5'd16, 5'd16));
          default: ;
        endcase
      end else begin
        case (c[3:1])
          3'd0: begin
            if (c[0]) begin
              l = push(l, ent(4'd0, 4'd0, 6'd16, 6'd16, 5'd16, 5'd8));
              l = push(l, ent(4'd0, 4'd8, 6'd16, 6'd56, 5'd16, 5'd8));
            end else begin
              l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd32, 5'd8, 5'd16));
              l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd32, 5'd8, 5'd16));
            end
          end
          3'd1: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd16, 5'd16, 5'd16));
            if (c[0]) l = push(l, ent(4'd8, 4'd8, 6'd40, 6'd8, 5'd8, 5'd8));
          end
          3'd2: begin
            l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd16, 5'd16, 5'd16));
            if (c[0]) l = push(l, ent(4'd0, 4'd8, 6'd32, 6'd8, 5'd8, 5'd8));
          end
          3'd3: begin
            l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd48, 5'd16, 5'd16));
            if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd0, 5'd8, 5'd8));
          end
          3'd4: begin
            l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd48, 5'd16, 5'd16));
            if (c[0]) l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd0, 5'd8, 5'd8));
          end
          default: ;
        endcase
      end
    end else if (c[4]) begin
      case (c[3:2])
        2'd0: begin
          l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd32, 5'd16, 5'd16));
          if (c[0]) l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd0, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd8, 4'd8, 6'd40, 6'd8, 5'd8, 5'd8));
        end
        2'd1: begin
          l = push(l, ent(4'd0, 4'd0, 6'd16, 6'd16, 5'd16, 5'd16));
          if (c[0]) l = push(l, ent(4'd8, 4'd8, 6'd40, 6'd8, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd0, 4'd8, 6'd32, 6'd8, 5'd8, 5'd8));
        end
        2'd2: begin
          l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd32, 5'd16, 5'd16));
          if (c[0]) l = push(l, ent(4'd0, 4'd8, 6'd32, 6'd8, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd0, 5'd8, 5'd8));
        end
        default: begin
          l = push(l, ent(4'd0, 4'd0, 6'd16, 6'd48, 5'd16, 5'd16));
          if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd0, 5'd8, 5'd8));
          if (c[1]) l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd0, 5'd8, 5'd8));
        end
      endcase
    end else begin
      if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd32, 6'd0, 5'd8, 5'd8));
      if (c[1]) l = push(l, ent(4'd8, 4'd0, 6'd40, 6'd0, 5'd8, 5'd8));
      if (c[2]) l = push(l, ent(4'd8, 4'd8, 6'd40, 6'd8, 5'd8, 5'd8));
      if (c[3]) l = push(l, ent(4'd0, 4'd8, 6'd32, 6'd8, 5'd8, 5'd8));
    end
    return l;
  endfunction

  function automatic rect_list_t depth_list(input logic [5:0] c);
    rect_list_t l;
    l = '0;
    if (c[0]) l = push(l, ent(4'd0, 4'd0, 6'd0, 6'd0, 5'd8, 5'd8));
    if (c[1]) l = push(l, ent(4'd8, 4'd0, 6'd8, 6'd0, 5'd8, 5'd8));
    if (c[2]) l = push(l, ent(4'd8, 4'd8, 6'd8, 6'd8, 5'd8, 5'd8));
    if (c[3]) l = push(l, ent(4'd0, 4'd8, 6'd0, 6'd8, 5'd8, 5'd8));
    return l;
  endfunction

  s1_t        s1;
  logic       s1_valid;
  s2_t        s2;
  s2_t        s2_next;
  logic       s2_valid;
  blit_item_t s3;
  blit_item_t s3_next;
  logic       s3_valid;

  logic       em_ready;
  logic       s1_free;
  logic       s2_free;
  logic       s3_free;

  logic [7:0] frame_x;
  logic [7:0] border_x;
  logic [4:0] terr_t;
  logic [7:0] terr_x;
  logic [7:0] terr_y;

  assign s3_free = !s3_valid || em_ready;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign tile.ready = s1_free;

  // source bases and rectangle list
  always_comb begin
    frame_x  = {2'd0, s1.frame, 4'd0};
    border_x = frame_x + (s1.border ? 8'd48 : 8'd0);
    terr_t   = {1'b0, s1.terrain_index} + 5'd4;
    terr_x   = (terr_t[0] ? 8'd48 : 8'd0) +
               ((terr_t[4:3] == 2'd2) ? 8'd192 : ((terr_t[4:3] == 2'd1) ? 8'd96 : 8'd0));
    terr_y   = {terr_t[2:1], 6'd0};

    s2_next.dest_x = s1.dest_x;
    s2_next.dest_y = s1.dest_y;
    s2_next.alt_x  = frame_x;
    s2_next.alt_y  = 8'd64 + {2'd0, s1.water_row, 4'd0};
    case (s1.op)
      OP_WATER: begin
        s2_next.base_x = border_x;
        s2_next.base_y = 8'd0;
        s2_next.list   = water_list(s1.comb);
      end
      OP_TERRAIN: begin
        s2_next.base_x = terr_x;
        s2_next.base_y = terr_y;
        s2_next.list   = terrain_list(s1.comb);
      end
      OP_DEPTH: begin
        s2_next.base_x = frame_x;
        s2_next.base_y = 8'd64 + {2'd0, s1.depth_row, 4'd0};
        s2_next.list   = depth_list(s1.comb);
      end
      default: begin
        s2_next.base_x = 8'd0;
        s2_next.base_y = 8'd0;
        s2_next.list   = '0;
      end
    endcase
  end

  // final source coordinates
  always_comb begin
    s3_next.dest_x = s2.dest_x;
    s3_next.dest_y = s2.dest_y;
    s3_next.count  = s2.list.count;
    for (int i = 0; i < MaxRects; i++) begin
      s3_next.e[i].ox  = s2.list.e[i].ox;
      s3_next.e[i].oy  = s2.list.e[i].oy;
      s3_next.e[i].w16 = s2.list.e[i].w16;
      s3_next.e[i].h16 = s2.list.e[i].h16;
      s3_next.e[i].sx  = (s2.list.e[i].alt ? s2.alt_x : s2.base_x) + {2'd0, s2.list.e[i].dx};
      s3_next.e[i].sy  = (s2.list.e[i].alt ? s2.alt_y : s2.base_y) + {2'd0, s2.list.e[i].dy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= tile.valid;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1.op            <= tile.operation;
      s1.dest_x        <= tile.dest_x;
      s1.dest_y        <= tile.dest_y;
      s1.frame         <= tile.frame;
      s1.border        <= tile.border;
      s1.water_row     <= tile.water_row;
      s1.terrain_index <= tile.terrain_index;
      s1.depth_row     <= tile.depth_row;
      s1.comb          <= tile.combination;
    end
    if (s2_free) s2 <= s2_next;
    if (s3_free) s3 <= s3_next;
  end

  astbg_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s3_valid),
    .item       (s3),
    .item_ready (em_ready),
    .blit       (blit)
  );

  `ASTBG_ASSERT_NEXT(a_tile_enters, clk, rst, tile.valid && tile.ready, s1_valid, "accepted tile not captured")
  `ASTBG_ASSERT_NEXT(a_depth_count, clk, rst, s1_valid && s1.op == OP_DEPTH && s2_free, s2.list.count == 3'($countones($past(s1.comb[3:0]))), "depth quarter count mismatch")
  `ASTBG_ASSERT_NEXT(a_terrain_bg, clk, rst, s1_valid && s1.op == OP_TERRAIN && s2_free, s2.list.count != 3'd0, "terrain tile without background")

endmodule

// ===== rtl/core/astbg_emit.sv =====
// rectangle sequencer: holds one tile's list and sends one rectangle per cycle while blit ready is high
`include "autotile_subtile_blit_generator_unit_defines.svh"

module astbg_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  astbg_pkg::blit_item_t item,
  output logic                 item_ready,
  astbg_blit_if.source         blit
);
  import astbg_pkg::*;

  blit_item_t  held;
  logic        busy;
  logic [2:0]  idx;
  logic        out_valid;
  logic [11:0] out_dst_x;
  logic [11:0] out_dst_y;
  logic [7:0]  out_src_x;
  logic [7:0]  out_src_y;
  logic [4:0]  out_width;
  logic [4:0]  out_height;
  logic        out_last;

  blit_ent_t cur;
  logic      out_free;
  logic      is_last;
  logic      fire;
  logic      done;

  assign cur      = held.e[idx];
  assign out_free = !out_valid || blit.ready;
  assign is_last  = (idx == held.count - 3'd1);
  assign fire     = busy && (held.count != 3'd0) && out_free;
  assign done     = busy && ((held.count == 3'd0) || (fire && is_last));
  assign item_ready = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        busy <= item_valid;
        idx  <= 3'd0;
      end else if (fire) begin
        idx <= idx + 3'd1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (blit.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      held <= item;
    end
    if (fire) begin
      out_dst_x  <= held.dest_x + {8'd0, cur.ox, 3'd0};
      out_dst_y  <= held.dest_y + {8'd0, cur.oy, 3'd0};
      out_src_x  <= cur.sx;
      out_src_y  <= cur.sy;
      out_width  <= cur.w16 ? 5'd16 : 5'd8;
      out_height <= cur.h16 ? 5'd16 : 5'd8;
      out_last   <= is_last;
    end
  end

  assign blit.valid       = out_valid;
  assign blit.dst_x       = out_dst_x;
  assign blit.dst_y       = out_dst_y;
  assign blit.src_x       = out_src_x;
  assign blit.src_y       = out_src_y;
  assign blit.rect_width  = out_width;
  assign blit.rect_height = out_height;
  assign blit.last        = out_last;

  `ASTBG_ASSERT(a_idx_in_list, clk, rst, busy && held.count != 3'd0 |-> idx < held.count, "rectangle index past end of list")
  `ASTBG_ASSERT(a_count_bound, clk, rst, busy |-> held.count <= 3'(MaxRects), "rectangle count too large")
  `ASTBG_ASSERT_NEXT(a_last_frees, clk, rst, fire && is_last, !busy || idx == 3'd0, "sequencer not released after last rectangle")

endmodule

// ===== dv/autotile_subtile_blit_generator_unit_tb.sv =====
// self-checking testbench for the autotile blit generator: directed and random tiles
`timescale 1ns / 1ps

module autotile_subtile_blit_generator_unit_tb;
  import astbg_pkg::*;

  localparam logic [1:0] OpNone = 2'd3;
  localparam int CycleLimit = 300000;
  localparam int RandomTiles = 387;
  localparam int QuietTail = 40;
  localparam int DrainCycles = 24;
  localparam int PressureCycles = 120;
  localparam int PressureStep = 160;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [1:0]  frame;
    logic        border;
    logic [1:0]  water_row;
    logic [3:0]  terrain_index;
    logic [1:0]  depth_row;
    logic [5:0]  combination;
  } tile_req_t;

  typedef struct packed {
    logic [11:0] dst_x;
    logic [11:0] dst_y;
    logic [7:0]  src_x;
    logic [7:0]  src_y;
    logic [4:0]  rect_width;
    logic [4:0]  rect_height;
    logic        last;
  } blit_rect_t;

  logic clk;
  logic rst;

  astbg_tile_if tile_ch ();
  astbg_blit_if blit_ch ();

  autotile_subtile_blit_generator_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .tile (tile_ch),
    .blit (blit_ch)
  );

  tile_req_t  pending_tiles[$];
  blit_rect_t expected_rects[$];
  blit_rect_t tile_rects[MaxRects];
  int         tile_rect_count;
  int         tile_base_x;
  int         tile_base_y;
  tile_req_t  cur_tile;
  int         total_tiles;
  int         tiles_sent;
  int         error_count;
  int         cycle_count;
  int         pressure_left;
  int         pressure_mark;
  int         send_gap;
  int         send_calm;
  int         sink_gap;
  int         sink_calm;

  function automatic void add_blit(int ox, int oy, int sx, int sy, int w, int h);
    blit_rect_t r;
    if (tile_rect_count >= MaxRects) return;
    r.dst_x = 12'(tile_base_x + ox);
    r.dst_y = 12'(tile_base_y + oy);
    r.src_x = 8'(sx);
    r.src_y = 8'(sy);
    r.rect_width = 5'(w);
    r.rect_height = 5'(h);
    r.last = 1'b0;
    tile_rects[tile_rect_count] = r;
    tile_rect_count++;
  endfunction

  function automatic void water_blits(int frame, int border, int row, logic [5:0] c);
    int f;
    int b;
    f = frame * 16;
    b = f + border * 48;
    add_blit(0, 0, f, 64 + row * 16, 16, 16);
    if (c[5]) begin
      if (c > 6'h29) begin
        case (c)
          6'h2A: begin add_blit(0, 0, b, 0, 16, 8); add_blit(0, 8, b, 24, 16, 8); end
          6'h2B: begin add_blit(0, 0, b, 0, 8, 16); add_blit(8, 0, b + 8, 32, 8, 16); end
          6'h2C: begin add_blit(0, 8, b, 8, 16, 8); add_blit(0, 0, b, 16, 16, 8); end
          6'h2D: begin add_blit(8, 0, b + 8, 0, 8, 16); add_blit(0, 0, b, 32, 8, 16); end
          6'h2E: add_blit(0, 0, b, 0, 16, 16);
          default: ;
        endcase
      end else begin
        case (c[3:1])
          3'd0: begin
            if (c[0]) add_blit(0, 0, b, 32, 16, 16);
            else add_blit(0, 0, b, 16, 16, 16);
          end
          3'd1: begin
            add_blit(0, 0, b, 0, 8, 8); add_blit(0, 8, b, 24, 8, 8);
            add_blit(8, 0, b + 8, 32, 8, 8);
            if (c[0]) add_blit(8, 8, b + 8, 56, 8, 8);
          end
          3'd2: begin
            add_blit(8, 0, b + 8, 0, 8, 8); add_blit(8, 8, b + 8, 24, 8, 8);
            add_blit(0, 0, b, 32, 8, 8);
            if (c[0]) add_blit(0, 8, b, 56, 8, 8);
          end
          3'd3: begin
            add_blit(8, 8, b + 8, 8, 8, 8); add_blit(8, 0, b + 8, 16, 8, 8);
            add_blit(0, 8, b, 40, 8, 8);
            if (c[0]) add_blit(0, 0, b, 48, 8, 8);
          end
          3'd4: begin
            add_blit(0, 8, b, 8, 8, 8); add_blit(0, 0, b, 16, 8, 8);
            add_blit(8, 8, b + 8, 40, 8, 8);
            if (c[0]) add_blit(8, 0, b + 8, 48, 8, 8);
          end
          default: ;
        endcase
      end
    end else if (c[4]) begin
      case (c[3:2])
        2'd0: begin
          add_blit(0, 0, b, 16, 8, 16);
          if (c[0]) add_blit(8, 0, b + 8, 48, 8, 8);
          if (c[1]) add_blit(8, 8, b + 8, 56, 8, 8);
        end
        2'd1: begin
          add_blit(0, 0, b, 32, 16, 8);
          if (c[0]) add_blit(8, 8, b + 8, 56, 8, 8);
          if (c[1]) add_blit(0, 8, b, 56, 8, 8);
        end
        2'd2: begin
          add_blit(8, 0, b + 8, 16, 8, 16);
          if (c[0]) add_blit(0, 8, b, 56, 8, 8);
          if (c[1]) add_blit(0, 0, b, 48, 8, 8);
        end
        default: begin
          add_blit(0, 8, b, 40, 16, 8);
          if (c[0]) add_blit(0, 0, b, 48, 8, 8);
          if (c[1]) add_blit(8, 0, b + 8, 48, 8, 8);
        end
      endcase
    end else begin
      if (c[0]) add_blit(0, 0, b, 48, 8, 8);
      if (c[1]) add_blit(8, 0, b + 8, 48, 8, 8);
      if (c[2]) add_blit(8, 8, b + 8, 56, 8, 8);
      if (c[3]) add_blit(0, 8, b, 56, 8, 8);
    end
  endfunction

  function automatic void terrain_blits(int index, logic [5:0] c);
    int t;
    int x;
    int y;
    t = index + 4;
    x = (t % 2) * 48 + (t / 8) * 96;
    y = ((t / 2) % 4) * 64;
    add_blit(0, 0, x + 16, y + 32, 16, 16);
    if (c[5]) begin
      if (c > 6'h29) begin
        case (c)
          6'h2A: begin
            add_blit(0, 0, x, y + 16, 8, 16); add_blit(8, 0, x + 40, y + 16, 8, 16);
          end
          6'h2B: begin
            add_blit(0, 0, x, y + 16, 16, 8); add_blit(0, 8, x, y + 56, 16, 8);
          end
          6'h2C: begin
            add_blit(0, 0, x, y + 48, 8, 16); add_blit(8, 0, x + 40, y + 48, 8, 16);
          end
          6'h2D: begin
            add_blit(0, 0, x + 32, y + 16, 16, 8); add_blit(0, 8, x + 32, y + 56, 16, 8);
          end
          6'h2E: begin
            add_blit(0, 0, x, y + 16, 8, 8); add_blit(8, 0, x + 40, y + 16, 8, 8);
            add_blit(0, 8, x, y + 56, 8, 8); add_blit(8, 8, x + 40, y + 56, 8, 8);
          end
          6'h31: add_blit(0, 0, x, y, 16, 16);
          default: ;
        endcase
      end else begin
        case (c[3:1])
          3'd0: begin
            if (c[0]) begin
              add_blit(0, 0, x + 16, y + 16, 16, 8); add_blit(0, 8, x + 16, y + 56, 16, 8);
            end else begin
              add_blit(0, 0, x, y + 32, 8, 16); add_blit(8, 0, x + 40, y + 32, 8, 16);
            end
          end
          3'd1: begin
            add_blit(0, 0, x, y + 16, 16, 16);
            if (c[0]) add_blit(8, 8, x + 40, y + 8, 8, 8);
          end
          3'd2: begin
            add_blit(0, 0, x + 32, y + 16, 16, 16);
            if (c[0]) add_blit(0, 8, x + 32, y + 8, 8, 8);
          end
          3'd3: begin
            add_blit(0, 0, x + 32, y + 48, 16, 16);
            if (c[0]) add_blit(0, 0, x + 32, y, 8, 8);
          end
          3'd4: begin
            add_blit(0, 0, x, y + 48, 16, 16);
            if (c[0]) add_blit(8, 0, x + 40, y, 8, 8);
          end
          default: ;
        endcase
      end
    end else if (c[4]) begin
      case (c[3:2])
        2'd0: begin
          add_blit(0, 0, x, y + 32, 16, 16);
          if (c[0]) add_blit(8, 0, x + 40, y, 8, 8);
          if (c[1]) add_blit(8, 8, x + 40, y + 8, 8, 8);
        end
        2'd1: begin
          add_blit(0, 0, x + 16, y + 16, 16, 16);
          if (c[0]) add_blit(8, 8, x + 40, y + 8, 8, 8);
          if (c[1]) add_blit(0, 8, x + 32, y + 8, 8, 8);
        end
        2'd2: begin
          add_blit(0, 0, x + 32, y + 32, 16, 16);
          if (c[0]) add_blit(0, 8, x + 32, y + 8, 8, 8);
          if (c[1]) add_blit(0, 0, x + 32, y, 8, 8);
        end
        default: begin
          add_blit(0, 0, x + 16, y + 48, 16, 16);
          if (c[0]) add_blit(0, 0, x + 32, y, 8, 8);
          if (c[1]) add_blit(8, 0, x + 40, y, 8, 8);
        end
      endcase
    end else begin
      if (c[0]) add_blit(0, 0, x + 32, y, 8, 8);
      if (c[1]) add_blit(8, 0, x + 40, y, 8, 8);
      if (c[2]) add_blit(8, 8, x + 40, y + 8, 8, 8);
      if (c[3]) add_blit(0, 8, x + 32, y + 8, 8, 8);
    end
  endfunction

  function automatic void depth_blits(int frame, int row, logic [5:0] c);
    int f;
    int sy;
    f = frame * 16;
    sy = 64 + row * 16;
    if (c[0]) add_blit(0, 0, f, sy, 8, 8);
    if (c[1]) add_blit(8, 0, f + 8, sy, 8, 8);
    if (c[2]) add_blit(8, 8, f + 8, sy + 8, 8, 8);
    if (c[3]) add_blit(0, 8, f, sy + 8, 8, 8);
  endfunction

  function automatic void compose_blits(tile_req_t t);
    tile_rect_count = 0;
    tile_base_x = t.dest_x;
    tile_base_y = t.dest_y;
    case (t.operation)
      OP_WATER:   water_blits(t.frame, t.border, t.water_row, t.combination);
      OP_TERRAIN: terrain_blits(t.terrain_index, t.combination);
      OP_DEPTH:   depth_blits(t.frame, t.depth_row, t.combination);
      default: ;
    endcase
    if (tile_rect_count > 0) tile_rects[tile_rect_count - 1].last = 1'b1;
    for (int i = 0; i < tile_rect_count; i++) expected_rects.push_back(tile_rects[i]);
  endfunction

  function automatic logic [11:0] random_dest();
    if ($urandom_range(0, 9) == 0) return 12'hFF0 + 12'($urandom_range(0, 15));
    return 12'($urandom);
  endfunction

  function automatic tile_req_t random_tile();
    tile_req_t t;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) t.operation = OP_WATER;
    else if (pick < 75) t.operation = OP_TERRAIN;
    else if (pick < 95) t.operation = OP_DEPTH;
    else t.operation = OpNone;
    t.dest_x = random_dest();
    t.dest_y = random_dest();
    t.frame = 2'($urandom);
    t.border = 1'($urandom);
    t.water_row = 2'($urandom);
    t.terrain_index = 4'($urandom);
    t.depth_row = 2'($urandom);
    // bias toward the listed wall and corner codes
    if ($urandom_range(0, 3) == 0) t.combination = 6'($urandom_range(32'h20, 32'h31));
    else t.combination = 6'($urandom);
    return t;
  endfunction

  task automatic add_directed(logic [1:0] op, logic [11:0] dx, logic [11:0] dy, logic [1:0] fr,
                              logic bd, logic [1:0] wr, logic [3:0] ti, logic [1:0] dr,
                              logic [5:0] comb);
    tile_req_t t;
    t.operation = op;
    t.dest_x = dx;
    t.dest_y = dy;
    t.frame = fr;
    t.border = bd;
    t.water_row = wr;
    t.terrain_index = ti;
    t.depth_row = dr;
    t.combination = comb;
    pending_tiles.push_back(t);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_blit();
    blit_rect_t want;
    if (expected_rects.size() == 0) begin
      report_mismatch("blit rectangle with none expected");
      return;
    end
    want = expected_rects.pop_front();
    check_field("dst_x", blit_ch.dst_x, want.dst_x);
    check_field("dst_y", blit_ch.dst_y, want.dst_y);
    check_field("src_x", blit_ch.src_x, want.src_x);
    check_field("src_y", blit_ch.src_y, want.src_y);
    check_field("rect_width", blit_ch.rect_width, want.rect_width);
    check_field("rect_height", blit_ch.rect_height, want.rect_height);
    check_field("last", blit_ch.last, want.last);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    tile_ch.valid = 1'b0;
    tile_ch.operation = OP_WATER;
    tile_ch.dest_x = '0;
    tile_ch.dest_y = '0;
    tile_ch.frame = '0;
    tile_ch.border = 1'b0;
    tile_ch.water_row = '0;
    tile_ch.terrain_index = '0;
    tile_ch.depth_row = '0;
    tile_ch.combination = '0;
    blit_ch.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    tiles_sent = 0;

    // field extremes, every kind, unlisted codes, empty depth, unused kind, wrap
    add_directed(OP_WATER, 12'd0, 12'd0, 2'd0, 1'b0, 2'd0, 4'd0, 2'd0, 6'h00);
    add_directed(OP_WATER, 12'hFFF, 12'hFFF, 2'd3, 1'b1, 2'd3, 4'd15, 2'd3, 6'h0F);
    add_directed(OP_WATER, 12'd4080, 12'd4080, 2'd1, 1'b1, 2'd2, 4'd0, 2'd0, 6'h1F);
    add_directed(OP_WATER, 12'd16, 12'd32, 2'd2, 1'b0, 2'd1, 4'd0, 2'd0, 6'h23);
    add_directed(OP_WATER, 12'd48, 12'd64, 2'd3, 1'b1, 2'd0, 4'd0, 2'd0, 6'h2E);
    add_directed(OP_WATER, 12'd80, 12'd96, 2'd0, 1'b1, 2'd3, 4'd0, 2'd0, 6'h2F);
    add_directed(OP_WATER, 12'd112, 12'd128, 2'd1, 1'b0, 2'd2, 4'd0, 2'd0, 6'h3F);
    add_directed(OP_WATER, 12'd144, 12'd160, 2'd2, 1'b1, 2'd1, 4'd0, 2'd0, 6'h21);
    add_directed(OP_WATER, 12'd176, 12'd192, 2'd3, 1'b0, 2'd0, 4'd0, 2'd0, 6'h29);
    add_directed(OP_TERRAIN, 12'd0, 12'd0, 2'd0, 1'b0, 2'd0, 4'd0, 2'd0, 6'h00);
    add_directed(OP_TERRAIN, 12'hFFF, 12'hFFF, 2'd0, 1'b0, 2'd0, 4'd11, 2'd0, 6'h31);
    add_directed(OP_TERRAIN, 12'd208, 12'd224, 2'd0, 1'b0, 2'd0, 4'd15, 2'd0, 6'h2E);
    add_directed(OP_TERRAIN, 12'd240, 12'd256, 2'd0, 1'b0, 2'd0, 4'd12, 2'd0, 6'h3F);
    add_directed(OP_TERRAIN, 12'd272, 12'd288, 2'd0, 1'b0, 2'd0, 4'd5, 2'd0, 6'h13);
    add_directed(OP_TERRAIN, 12'd304, 12'd320, 2'd0, 1'b0, 2'd0, 4'd7, 2'd0, 6'h0F);
    add_directed(OP_TERRAIN, 12'd336, 12'd352, 2'd0, 1'b0, 2'd0, 4'd14, 2'd0, 6'h2A);
    add_directed(OP_TERRAIN, 12'd368, 12'd384, 2'd0, 1'b0, 2'd0, 4'd3, 2'd0, 6'h30);
    add_directed(OP_DEPTH, 12'd0, 12'd0, 2'd0, 1'b0, 2'd0, 4'd0, 2'd0, 6'h00);
    add_directed(OP_DEPTH, 12'hFFF, 12'hFFF, 2'd3, 1'b1, 2'd3, 4'd15, 2'd3, 6'h0F);
    add_directed(OP_DEPTH, 12'd400, 12'd416, 2'd1, 1'b0, 2'd0, 4'd0, 2'd1, 6'h30);
    add_directed(OP_DEPTH, 12'd432, 12'd448, 2'd2, 1'b0, 2'd0, 4'd0, 2'd2, 6'h35);
    add_directed(OpNone, 12'hFFF, 12'hFFF, 2'd3, 1'b1, 2'd3, 4'd15, 2'd3, 6'h3F);
    add_directed(OP_WATER, 12'd464, 12'd480, 2'd0, 1'b0, 2'd3, 4'd0, 2'd0, 6'h18);

    for (int n = 0; n < RandomTiles; n++) begin
      tile_req_t t;
      t = random_tile();
      pending_tiles.push_back(t);
    end
    total_tiles = pending_tiles.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (tiles_sent != total_tiles || expected_rects.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // tile request driver
  always @(posedge clk) begin
    if (rst) begin
      tile_ch.valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
    end else begin
      if (tile_ch.valid && tile_ch.ready) begin
        compose_blits(cur_tile);
        tiles_sent <= tiles_sent + 1;
      end
      if (!tile_ch.valid || tile_ch.ready) begin
        if (send_gap == 0 && send_calm == 0 && pending_tiles.size() > QuietTail &&
            $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 11);
          send_calm = $urandom_range(0, 30);
        end
        if (send_gap > 0) begin
          send_gap--;
          tile_ch.valid <= 1'b0;
        end else if (pending_tiles.size() != 0) begin
          cur_tile = pending_tiles.pop_front();
          if (send_calm > 0) send_calm--;
          tile_ch.operation <= cur_tile.operation;
          tile_ch.dest_x <= cur_tile.dest_x;
          tile_ch.dest_y <= cur_tile.dest_y;
          tile_ch.frame <= cur_tile.frame;
          tile_ch.border <= cur_tile.border;
          tile_ch.water_row <= cur_tile.water_row;
          tile_ch.terrain_index <= cur_tile.terrain_index;
          tile_ch.depth_row <= cur_tile.depth_row;
          tile_ch.combination <= cur_tile.combination;
          tile_ch.valid <= 1'b1;
        end else begin
          tile_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and tile ready drops
  always @(posedge clk) begin
    if (rst) begin
      pressure_left <= 0;
      pressure_mark <= 100;
    end else if (pressure_left != 0) begin
      pressure_left <= pressure_left - 1;
    end else if (tiles_sent >= pressure_mark && tiles_sent + QuietTail < total_tiles) begin
      pressure_left <= PressureCycles;
      pressure_mark <= pressure_mark + PressureStep;
    end
  end

  // blit rectangle monitor
  always @(posedge clk) begin
    if (rst) begin
      blit_ch.ready <= 1'b0;
      sink_gap = 0;
      sink_calm = 0;
    end else begin
      if (blit_ch.valid && blit_ch.ready) begin
        check_blit();
        if (sink_calm > 0) sink_calm--;
      end
      if (sink_gap == 0 && sink_calm == 0 && tiles_sent + QuietTail < total_tiles &&
          $urandom_range(0, 6) == 0) begin
        sink_gap = $urandom_range(1, 11);
        sink_calm = $urandom_range(0, 40);
      end
      if (pressure_left != 0 || sink_gap > 0) begin
        if (sink_gap > 0) sink_gap--;
        blit_ch.ready <= 1'b0;
      end else begin
        blit_ch.ready <= 1'b1;
      end
    end
  end

endmodule

// ===== autotile_subtile_blit_generator_unit.f =====
+incdir+rtl/core
rtl/core/astbg_pkg.sv
rtl/core/astbg_tile_if.sv
rtl/core/astbg_blit_if.sv
rtl/core/astbg_emit.sv
rtl/core/autotile_subtile_blit_generator_unit.sv
dv/autotile_subtile_blit_generator_unit_tb.sv
